[sv/lcfpe_pkg.sv]
`timescale 1ns / 1ps

package lcfpe_pkg;

	localparam int LED_COUNT = 64;
	localparam int IDX_W = $clog2(LED_COUNT);
	localparam int EDGE_BITS = 7;

	localparam logic [LED_COUNT-1:0] ROW_KEEP_MASK = 64'h7777_7777_7777_7777;

	localparam logic [IDX_W-1:0] SCROLL_TARGETS [EDGE_BITS] = '{
		6'd51, 6'd35, 6'd19, 6'd3, 6'd7, 6'd11, 6'd15
	};

	localparam logic [2:0] REQ_FILL      = 3'd0;
	localparam logic [2:0] REQ_SET       = 3'd1;
	localparam logic [2:0] REQ_CLEAR     = 3'd2;
	localparam logic [2:0] REQ_CLEAR_ALL = 3'd3;
	localparam logic [2:0] REQ_SCROLL    = 3'd4;
	localparam logic [2:0] REQ_READ      = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FILL_ON,
		ST_FILL_OFF,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0]           sum;
		logic                 in_range;
		logic [LED_COUNT-1:0] mask;
	} idx_res_t;

endpackage

[sv/lcfpe_idx_unit.sv]
`timescale 1ns / 1ps

module lcfpe_idx_unit (
	input  logic [7:0]          idx,
	input  logic [7:0]          addend,
	output lcfpe_pkg::idx_res_t res
);
	import lcfpe_pkg::*;

	always_comb begin
		res.sum      = idx + addend;
		res.in_range = (idx < 8'(LED_COUNT));
		res.mask     = {{(LED_COUNT-1){1'b0}}, 1'b1} << idx[IDX_W-1:0];
	end

endmodule

[sv/led_cube_frame_pattern_engine.sv]
// led cube frame pattern engine: one command word at a time
// set, clear, clear all, scroll, read: applied in the exec state, then the done strobe
// pattern fill: repeat_count runs of on_count leds, off_count skipped after each run,
// from start_index, one led position per fill-on cycle through the shared index adder
// busy stays high until the result cycle ends; the receiver cannot stall
// async active-low reset clears the frame and returns to idle
`timescale 1ns / 1ps

module led_cube_frame_pattern_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     req_type,
	input  logic [7:0]                     start_index,
	input  logic [7:0]                     on_count,
	input  logic [7:0]                     off_count,
	input  logic [7:0]                     repeat_count,
	input  logic [7:0]                     led_index,
	input  logic [6:0]                     scroll_byte,
	output logic                           done,
	output logic [lcfpe_pkg::LED_COUNT-1:0] frame_bits,
	output logic                           led_bit
);
	import lcfpe_pkg::*;

	state_t                state_q, state_d;
	logic [LED_COUNT-1:0]  frame_q, frame_d;
	logic                  led_q, led_d;
	logic [2:0]            req_q;
	logic [7:0]            pos_q, pos_d;
	logic [7:0]            on_q, off_q, idx_q;
	logic [7:0]            k_q, k_d;
	logic [7:0]            r_q, r_d;
	logic [EDGE_BITS-1:0]  edge_q;
	logic [7:0]            unit_idx, unit_add;
	idx_res_t              unit_res;

	lcfpe_idx_unit u_idx (
		.idx    (unit_idx),
		.addend (unit_add),
		.res    (unit_res)
	);

	assign busy       = (state_q != ST_IDLE);
	assign done       = (state_q == ST_DONE);
	assign frame_bits = frame_q;
	assign led_bit    = led_q;

	always_comb begin
		unit_idx = idx_q;
		unit_add = 8'd1;
		if (state_q == ST_FILL_ON || state_q == ST_FILL_OFF) begin
			unit_idx = pos_q;
		end
		if (state_q == ST_FILL_OFF) begin
			unit_add = off_q;
		end
	end

	always_comb begin
		state_d = state_q;
		frame_d = frame_q;
		led_d   = led_q;
		pos_d   = pos_q;
		k_d     = k_q;
		r_d     = r_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
					led_d   = 1'b0;
					pos_d   = start_index;
					k_d     = on_count;
					r_d     = repeat_count;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (req_q)
					REQ_FILL: begin
						if (on_q != 8'd0 && r_q != 8'd0) begin
							state_d = ST_FILL_ON;
						end
					end
					REQ_SET: begin
						if (unit_res.in_range) begin
							frame_d = frame_q | unit_res.mask;
						end
					end
					REQ_CLEAR: begin
						if (unit_res.in_range) begin
							frame_d = frame_q & ~unit_res.mask;
						end
					end
					REQ_CLEAR_ALL: begin
						frame_d = '0;
					end
					REQ_SCROLL: begin
						frame_d = (frame_q >> 1) & ROW_KEEP_MASK;
						for (int b = 0; b < EDGE_BITS; b++) begin
							if (edge_q[b]) begin
								frame_d[SCROLL_TARGETS[b]] = 1'b1;
							end
						end
					end
					REQ_READ: begin
						led_d = unit_res.in_range & |(frame_q & unit_res.mask);
					end
					default: begin
					end
				endcase
			end
			ST_FILL_ON: begin
				if (unit_res.in_range) begin
					frame_d = frame_q | unit_res.mask;
				end
				pos_d = unit_res.sum;
				k_d   = k_q - 8'd1;
				if (k_q == 8'd1) begin
					state_d = ST_FILL_OFF;
				end
			end
			ST_FILL_OFF: begin
				pos_d = unit_res.sum;
				r_d   = r_q - 8'd1;
				k_d   = on_q;
				if (r_q == 8'd1) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FILL_ON;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			frame_q <= '0;
			led_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			frame_q <= frame_d;
			led_q   <= led_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		k_q   <= k_d;
		r_q   <= r_d;
		if (state_q == ST_IDLE && start) begin
			req_q  <= req_type;
			on_q   <= on_count;
			off_q  <= off_count;
			idx_q  <= led_index;
			edge_q <= scroll_byte;
		end
	end

endmodule
